@@ hw/rtl/multi_channel_byte_ring_queues_macros.svh @@
// Assertion macros used by the byte ring queue datapath.
`ifndef MULTI_CHANNEL_BYTE_RING_QUEUES_MACROS_SVH
`define MULTI_CHANNEL_BYTE_RING_QUEUES_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define MCBRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define MCBRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mcbrq_pkg.sv @@
// Types, constants and codes shared by the byte ring queue modules.
package mcbrq_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 6;
  localparam int unsigned RING_DEPTH_DEF   = 1024;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CHAN_W           = 3;
  localparam int unsigned FILL_W           = 11;

  typedef enum logic {
    REQ_PUT = 1'b0,
    REQ_GET = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic              direction;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              was_empty;
    logic              was_dropped;
    logic              bad_channel;
    logic [FILL_W-1:0] fill_level;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_rsp;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/mcbrq_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface mcbrq_req_if
  import mcbrq_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mcbrq_rsp_if
  import mcbrq_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mcbrq_ctrl.sv @@
// Sequencing state machine: accept, ring access, result hand-off.
module mcbrq_ctrl
  import mcbrq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the phases of one transaction
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.load_rsp = status_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/mcbrq_datapath.sv @@
// Ring pointers, fill counts, byte storage and the response register.
`include "multi_channel_byte_ring_queues_macros.svh"

module mcbrq_datapath
  import mcbrq_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  req_t    req_i,
  input  logic    rsp_ready_i,
  output logic    rsp_valid_o,
  output rsp_t    rsp_o
);

  localparam int unsigned RING_COUNT = 2 * NUM_CHANNELS;
  localparam int unsigned RING_W     = $clog2(RING_COUNT);
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned MEM_DEPTH  = RING_COUNT * RING_DEPTH;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);

  req_t              req_q;
  logic [PTR_W-1:0]  head_q [RING_COUNT];
  logic [PTR_W-1:0]  tail_q [RING_COUNT];
  logic [CNT_W-1:0]  fill_q [RING_COUNT];
  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic              chan_ok;
  logic [CHAN_W+1:0] ring_sum;
  logic [RING_W-1:0] ring;
  logic [PTR_W-1:0]  cur_head, cur_tail, ptr_sel, ptr_next;
  logic [CNT_W-1:0]  cur_fill, fill_after;
  logic              is_put, full, empty, put_ok, get_ok;
  logic [ADDR_W-1:0] base, mem_addr;
  logic              mem_we, mem_re;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  logic              get_ok_q, was_empty_q, was_dropped_q, bad_q;
  logic [FILL_W-1:0] fill_lvl_q;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  // Capture the request at acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  // Select the ring and classify the request
  assign chan_ok  = {1'b0, req_q.channel} < (CHAN_W + 1)'(NUM_CHANNELS);
  assign ring_sum = (req_q.direction ? (CHAN_W + 2)'(NUM_CHANNELS) : '0)
                  + {2'b00, req_q.channel};
  assign ring     = ring_sum[RING_W-1:0];
  assign cur_head = head_q[ring];
  assign cur_tail = tail_q[ring];
  assign cur_fill = fill_q[ring];
  assign is_put   = (req_q.req_type == REQ_PUT);
  assign full     = (cur_fill == CNT_W'(RING_DEPTH));
  assign empty    = (cur_fill == '0);
  assign put_ok   = chan_ok && is_put && !full;
  assign get_ok   = chan_ok && !is_put && !empty;

  // Form the storage address and the advanced pointer
  assign ptr_sel  = is_put ? cur_tail : cur_head;
  assign ptr_next = (ptr_sel == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
  assign base     = ADDR_W'(32'(ring) * RING_DEPTH);
  assign mem_addr = base + ADDR_W'(ptr_sel);
  assign mem_we   = cmd_i.exec && put_ok;
  assign mem_re   = cmd_i.exec && get_ok;

  always_comb begin
    if (!chan_ok) begin
      fill_after = '0;
    end else if (put_ok) begin
      fill_after = cur_fill + 1'b1;
    end else if (get_ok) begin
      fill_after = cur_fill - 1'b1;
    end else begin
      fill_after = cur_fill;
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, fill_after};

  // Update pointers and fill counts of the addressed ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (put_ok) begin
        tail_q[ring] <= ptr_next;
        fill_q[ring] <= fill_after;
      end
      if (get_ok) begin
        head_q[ring] <= ptr_next;
        fill_q[ring] <= fill_after;
      end
    end
  end

  // Byte storage, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= req_q.data_in;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  // Hold the outcome of the ring access
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      get_ok_q      <= get_ok;
      was_empty_q   <= chan_ok && !is_put && empty;
      was_dropped_q <= chan_ok && is_put && full;
      bad_q         <= !chan_ok;
      fill_lvl_q    <= fill_ext[FILL_W-1:0];
    end
  end

  // Build and hold the response transaction
  always_comb begin
    rsp_d             = '0;
    rsp_d.data_out    = get_ok_q ? rd_q : '0;
    rsp_d.was_empty   = was_empty_q;
    rsp_d.was_dropped = was_dropped_q;
    rsp_d.bad_channel = bad_q;
    rsp_d.fill_level  = fill_lvl_q;
  end

  always_comb begin
    if (cmd_i.load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) rsp_q <= rsp_d;
  end

  assign status_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_o             = rsp_q;

  `MCBRQ_ASSERT(a_load_when_free, clk_i, rst_ni, !cmd_i.load_rsp || status_o.out_free, "response overwritten before taken")
  `MCBRQ_ASSERT(a_one_flag, clk_i, rst_ni, !rsp_valid_q || $countones({rsp_q.was_empty, rsp_q.was_dropped, rsp_q.bad_channel}) <= 1, "conflicting response flags")
  `MCBRQ_ASSERT(a_data_on_get, clk_i, rst_ni, !rsp_valid_q || rsp_q.data_out == '0 || !(rsp_q.was_empty || rsp_q.was_dropped || rsp_q.bad_channel), "data returned on a failed request")
  `MCBRQ_ASSERT_NEXT(a_put_fills, clk_i, rst_ni, mem_we, fill_q[$past(ring)] != '0, "ring empty right after a stored byte")

endmodule

@@ hw/rtl/multi_channel_byte_ring_queues.sv @@
// Top level of the multi-channel byte ring queue bank.
//
//   channel  dir  modport  contents
//   req_i    in   sink     req_type, direction, channel, data_in
//   rsp_o    out  source   data_out, was_empty, was_dropped, bad_channel, fill_level
//
// Each transaction runs through accept, ring access (pointer update and the
// single storage port), and result load into the output register.
// A new request is accepted only after the last result has been loaded.
// A response not yet taken holds the block in its result phase.
// Reset clears all head and tail pointers and fill counts at once; the byte
// storage is not cleared and needs no clearing pass.
module multi_channel_byte_ring_queues
  import mcbrq_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcbrq_req_if.sink   req_i,
  mcbrq_rsp_if.source rsp_o
);

  cmd_t    cmd;
  status_t status;
  logic    req_ready;
  logic    rsp_valid;
  rsp_t    rsp_payload;

  mcbrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcbrq_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .RING_DEPTH   (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i.payload),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_payload)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

endmodule
